FILE: src/srr_pkg.sv
// shared types, codes and constants of the selective-repeat receiver
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

  // default sizes handed to the top level parameters
  localparam int SEQ_SPACE_MAX_DEF = 16;
  localparam int WINDOW_MAX_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF  = 32;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int PKT_KIND_W = 3;
  localparam int PEER_W     = 8;
  localparam int RES_KIND_W = 3;
  localparam int LINK_W     = 2;
  localparam int RESEND_W   = 8;
  localparam int IDLE_W     = 20;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_SEQ_MODULUS    = 2'd0;
  localparam logic [1:0] REG_LOCAL_WINDOW   = 2'd1;
  localparam logic [1:0] REG_MAX_RESENDS    = 2'd2;
  localparam logic [1:0] REG_IDLE_TIMEOUT   = 2'd3;

  localparam int SEQ_MODULUS_RST  = 10;
  localparam int LOCAL_WINDOW_RST = 5;
  localparam int MAX_RESENDS_RST  = 10;
  localparam int IDLE_TIMEOUT_RST = 10000;

  // packet kinds on the wire
  localparam logic [PKT_KIND_W-1:0] PKT_SYN  = 3'd0;
  localparam logic [PKT_KIND_W-1:0] PKT_ACK  = 3'd1;
  localparam logic [PKT_KIND_W-1:0] PKT_FIN  = 3'd2;
  localparam logic [PKT_KIND_W-1:0] PKT_DATA = 3'd3;

  typedef enum logic [OP_W-1:0] {
    OP_PACKET,
    OP_TICK,
    OP_RETX,
    OP_IGNORED
  } op_t;

  typedef enum logic [RES_KIND_W-1:0] {
    RK_NONE,
    RK_SYNACK,
    RK_ACK,
    RK_NACK,
    RK_FIN,
    RK_DELIVER,
    RK_ENDED
  } res_kind_t;

  typedef enum logic [LINK_W-1:0] {
    LINK_LISTEN,
    LINK_SYNRCV,
    LINK_RECV,
    LINK_LASTACK
  } link_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

`default_nettype wire

FILE: src/srr_in_if.sv
// input item channel of the selective-repeat receiver
`timescale 1ns / 1ps
`default_nettype none

interface srr_in_if
  import srr_pkg::*;
#(
  parameter int SEQ_W        = 4,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [PKT_KIND_W-1:0]   packet_kind;
  logic                    packet_broken;
  logic [SEQ_W-1:0]        packet_seq;
  logic [PEER_W-1:0]       peer_window;
  logic [PAYLOAD_BITS-1:0] payload_word;

  modport source (
    output valid, operation, packet_kind, packet_broken, packet_seq, peer_window,
           payload_word,
    input  ready
  );

  modport sink (
    input  valid, operation, packet_kind, packet_broken, packet_seq, peer_window,
           payload_word,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/srr_out_if.sv
// result item channel of the selective-repeat receiver
`timescale 1ns / 1ps
`default_nettype none

interface srr_out_if
  import srr_pkg::*;
#(
  parameter int SEQ_W        = 4,
  parameter int WIN_W        = 4,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [RES_KIND_W-1:0]   result_kind;
  logic [SEQ_W-1:0]        reply_seq;
  logic [WIN_W-1:0]        reply_window;
  logic [PAYLOAD_BITS-1:0] delivered_word;
  logic                    last;
  logic [LINK_W-1:0]       link_state;

  modport source (
    output valid, result_kind, reply_seq, reply_window, delivered_word, last, link_state,
    input  ready
  );

  modport sink (
    input  valid, result_kind, reply_seq, reply_window, delivered_word, last, link_state,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/srr_alu.sv
// shared add/subtract and compare unit of the receiver sequencer
`timescale 1ns / 1ps
`default_nettype none

module srr_alu
  import srr_pkg::*;
#(
  parameter int W = 5
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] res,
  output logic         ge,
  output logic         eq
);

  assign res = (op == ALU_ADD) ? (a + b) : (a - b);
  assign ge  = (a >= b);
  assign eq  = (a == b);

endmodule

`default_nettype wire

FILE: src/selective_repeat_receiver.sv
// top level of the selective-repeat receiver with session setup and teardown
`timescale 1ns / 1ps
`default_nettype none

// Receiver side of a selective-repeat link. Every input item (packet arrival,
// millisecond tick or retransmit timer) yields one or more result items on the
// out channel, the final one flagged by last; every result carries the link
// state after the item and the agreed window. A small sequencer drives one
// shared add/subtract/compare unit; each item passes a latch, a decode and a
// closing state. An unbroken data frame also reduces the window head modulo
// the sequence modulus (one subtract per cycle, usually none) and works out
// its distance; one in the window but off its head then scans the reorder
// slots one at a time, a read and a compare per occupied slot and a read per
// empty one. A frame at the head of the window delivers its word and then
// rescans the slots for each next head, so a drain of WINDOW_MAX-1 parked
// frames rescans them once per delivered word. The block takes no new item
// until the last result of the current one has entered the output register;
// a stalled sink holds the sequencer at its next result. Configuration is an
// APB-style port with one register per 4 bytes: seq_modulus, local_window,
// max_resends and idle_timeout_ms, written only while the block is idle; the
// user must keep to that, as the block itself does not enforce it.
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int SEQ_SPACE_MAX = SEQ_SPACE_MAX_DEF,
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  srr_in_if.sink                 in_chan,
  srr_out_if.source              out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int SEQ_W = $clog2(SEQ_SPACE_MAX);
  localparam int MOD_W = $clog2(SEQ_SPACE_MAX + 1);
  localparam int UW    = $clog2(2 * SEQ_SPACE_MAX);
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int SLOTS = WINDOW_MAX - 1;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int AW0   = (WIN_W > MOD_W) ? WIN_W : MOD_W;
  localparam int AW    = (AW0 > PEER_W) ? AW0 : PEER_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_HEADMOD,
    S_RANGE,
    S_DIST,
    S_WRAP,
    S_WCHK,
    S_DUP_RD,
    S_DUP_CMP,
    S_DELIV,
    S_ADV,
    S_ADV2,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_PUSH,
    S_FIN_END,
    S_FIN_FIN,
    S_FLUSH
  } seq_state_t;

  // configuration registers
  logic [MOD_W-1:0]    cfg_mod_r;
  logic [WIN_W-1:0]    cfg_lwin_r;
  logic [RESEND_W-1:0] cfg_maxres_r;
  logic [IDLE_W-1:0]   cfg_timeout_r;

  // sequencer and session state
  seq_state_t          state_r;
  link_t               session_r;
  logic [WIN_W-1:0]    agreed_r;
  logic [SEQ_W-1:0]    head_r;
  logic [IDLE_W-1:0]   idle_r;
  logic [RESEND_W-1:0] tally_r;
  logic [SLOTS-1:0]    slot_valid_r;
  logic [UW-1:0]       tmp_r;
  logic [CNT_W-1:0]    scan_cnt_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;

  // latched input item
  op_t                     lat_op_r;
  logic [PKT_KIND_W-1:0]   lat_kind_r;
  logic                    lat_broken_r;
  logic [SEQ_W-1:0]        lat_seq_r;
  logic [PEER_W-1:0]       lat_peer_r;
  logic [PAYLOAD_BITS-1:0] lat_word_r;

  // reorder slot store and its registered read port
  logic [SEQ_W-1:0]        slot_seq_mem  [SLOTS];
  logic [PAYLOAD_BITS-1:0] slot_word_mem [SLOTS];
  logic [SEQ_W-1:0]        slot_seq_rd_r;
  logic [PAYLOAD_BITS-1:0] slot_word_rd_r;

  // pending result (held until we know whether it is the last) and output stage
  logic                    pend_valid_r;
  res_kind_t               pend_kind_r;
  logic [SEQ_W-1:0]        pend_seq_r;
  logic [PAYLOAD_BITS-1:0] pend_word_r;
  logic                    out_valid_r;
  res_kind_t               out_kind_r;
  logic [SEQ_W-1:0]        out_seq_r;
  logic [WIN_W-1:0]        out_win_r;
  logic [PAYLOAD_BITS-1:0] out_word_r;
  logic                    out_last_r;
  link_t                   out_link_r;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mod_r     <= MOD_W'(SEQ_MODULUS_RST);
      cfg_lwin_r    <= WIN_W'(LOCAL_WINDOW_RST);
      cfg_maxres_r  <= RESEND_W'(MAX_RESENDS_RST);
      cfg_timeout_r <= IDLE_W'(IDLE_TIMEOUT_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SEQ_MODULUS:  cfg_mod_r     <= pwdata[MOD_W-1:0];
        REG_LOCAL_WINDOW: cfg_lwin_r    <= pwdata[WIN_W-1:0];
        REG_MAX_RESENDS:  cfg_maxres_r  <= pwdata[RESEND_W-1:0];
        REG_IDLE_TIMEOUT: cfg_timeout_r <= pwdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEQ_MODULUS:  prdata = CFG_DW'(cfg_mod_r);
      REG_LOCAL_WINDOW: prdata = CFG_DW'(cfg_lwin_r);
      REG_MAX_RESENDS:  prdata = CFG_DW'(cfg_maxres_r);
      REG_IDLE_TIMEOUT: prdata = CFG_DW'(cfg_timeout_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // derived configuration values
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0] eff_mod;
  logic [AW-1:0]    lw_clamp;
  logic [AW-1:0]    half_mod;
  logic [AW-1:0]    peer_clamp;
  logic [AW-1:0]    win_a;
  logic [AW-1:0]    win_b;
  logic [WIN_W-1:0] agreed_calc;

  always_comb begin
    // modulus clamped to its legal span
    if (cfg_mod_r < MOD_W'(2)) begin
      eff_mod = MOD_W'(2);
    end else if (cfg_mod_r > MOD_W'(SEQ_SPACE_MAX)) begin
      eff_mod = MOD_W'(SEQ_SPACE_MAX);
    end else begin
      eff_mod = cfg_mod_r;
    end

    // window agreement: min of local window, half the modulus, peer offer
    if (cfg_lwin_r == '0) begin
      lw_clamp = AW'(1);
    end else if (AW'(cfg_lwin_r) > AW'(WINDOW_MAX)) begin
      lw_clamp = AW'(WINDOW_MAX);
    end else begin
      lw_clamp = AW'(cfg_lwin_r);
    end
    half_mod   = AW'(eff_mod >> 1);
    peer_clamp = (lat_peer_r == '0) ? AW'(1) : AW'(lat_peer_r);
    win_a       = (lw_clamp > half_mod) ? half_mod : lw_clamp;
    win_b       = (win_a > peer_clamp) ? peer_clamp : win_a;
    agreed_calc = WIN_W'(win_b);
  end

  // ---------------------------------------------------------------------------
  // decode of one item
  // ---------------------------------------------------------------------------
  logic                giveup;
  logic [IDLE_W-1:0]   idle_inc;
  seq_state_t          dec_fsm;
  link_t               dec_link;
  logic [RESEND_W-1:0] dec_tally;
  logic [IDLE_W-1:0]   dec_idle;
  logic                dec_clear;
  logic                dec_agree_ld;
  logic                dec_push;
  res_kind_t           dec_kind;

  assign giveup = ((session_r == LINK_SYNRCV) || (session_r == LINK_LASTACK)) &&
                  (tally_r >= cfg_maxres_r) && (lat_op_r != OP_IGNORED);
  // idle counter saturates
  assign idle_inc = (idle_r == '1) ? idle_r : (idle_r + IDLE_W'(1));

  always_comb begin
    dec_fsm      = S_FLUSH;
    dec_link     = session_r;
    dec_tally    = tally_r;
    dec_idle     = idle_r;
    dec_clear    = 1'b0;
    dec_agree_ld = 1'b0;
    dec_push     = 1'b0;
    dec_kind     = RK_NONE;
    if (giveup) begin
      dec_tally = '0;
      dec_link  = LINK_LISTEN;
    end else begin
      case (lat_op_r)
        OP_PACKET: begin
          case (session_r)
            LINK_LISTEN: begin
              if (lat_kind_r == PKT_SYN && !lat_broken_r) begin
                dec_agree_ld = 1'b1;
                dec_clear    = 1'b1;
                dec_link     = LINK_SYNRCV;
                dec_push     = 1'b1;
                dec_kind     = RK_SYNACK;
              end
            end
            LINK_SYNRCV: begin
              if (lat_kind_r == PKT_ACK && !lat_broken_r) begin
                dec_clear = 1'b1;
                dec_link  = LINK_RECV;
              end
            end
            LINK_RECV: begin
              if (lat_kind_r == PKT_DATA) begin
                // any frame, broken or not, counts as activity
                dec_idle = '0;
                dec_push = 1'b1;
                if (lat_broken_r) begin
                  dec_kind = RK_NACK;
                end else begin
                  dec_kind = RK_ACK;
                  dec_fsm  = S_HEADMOD;
                end
              end else if (lat_kind_r == PKT_FIN && !lat_broken_r) begin
                dec_push  = 1'b1;
                dec_kind  = RK_ACK;
                dec_tally = '0;
                dec_link  = LINK_LASTACK;
                dec_fsm   = S_FIN_END;
              end
            end
            LINK_LASTACK: begin
              if (lat_kind_r == PKT_ACK && !lat_broken_r) begin
                dec_tally = '0;
                dec_link  = LINK_LISTEN;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (session_r == LINK_RECV) begin
            dec_idle = idle_inc;
            if (idle_inc > cfg_timeout_r) begin
              dec_push  = 1'b1;
              dec_kind  = RK_ENDED;
              dec_tally = '0;
              dec_link  = LINK_LISTEN;
            end
          end
        end
        OP_RETX: begin
          if (session_r == LINK_SYNRCV) begin
            dec_tally = tally_r + RESEND_W'(1);
            dec_push  = 1'b1;
            dec_kind  = RK_SYNACK;
          end else if (session_r == LINK_LASTACK) begin
            dec_tally = tally_r + RESEND_W'(1);
            dec_push  = 1'b1;
            dec_kind  = RK_FIN;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared arithmetic unit, operands chosen by the sequencer
  // ---------------------------------------------------------------------------
  alu_op_t       alu_op;
  logic [UW-1:0] alu_a;
  logic [UW-1:0] alu_b;
  logic [UW-1:0] alu_res;
  logic          alu_ge;
  logic          alu_eq;

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      S_HEADMOD: begin
        alu_a = UW'(head_r);
        alu_b = UW'(eff_mod);
      end
      S_RANGE: begin
        alu_a = UW'(lat_seq_r);
        alu_b = UW'(eff_mod);
      end
      S_DIST: begin
        alu_a = UW'(lat_seq_r);
        alu_b = UW'(head_r);
      end
      S_WRAP: begin
        alu_op = ALU_ADD;
        alu_a  = tmp_r;
        alu_b  = UW'(eff_mod);
      end
      S_WCHK: begin
        alu_a = tmp_r;
        alu_b = UW'(agreed_r);
      end
      S_DUP_CMP: begin
        alu_a = UW'(slot_seq_rd_r);
        alu_b = UW'(lat_seq_r);
      end
      S_ADV: begin
        alu_op = ALU_ADD;
        alu_a  = UW'(head_r);
        alu_b  = UW'(1);
      end
      S_ADV2: begin
        alu_a = tmp_r;
        alu_b = UW'(eff_mod);
      end
      S_SCAN_CMP: begin
        alu_a = UW'(slot_seq_rd_r);
        alu_b = UW'(head_r);
      end
      default: ;
    endcase
  end

  srr_alu #(
    .W (UW)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge),
    .eq  (alu_eq)
  );

  // ---------------------------------------------------------------------------
  // result emission
  // ---------------------------------------------------------------------------
  logic                    out_free;
  logic                    can_push;
  logic                    push_req;
  res_kind_t               push_kind;
  logic [PAYLOAD_BITS-1:0] push_word;
  logic                    push_go;
  logic                    flush_go;

  assign out_free = !out_valid_r || out_chan.ready;
  assign can_push = !pend_valid_r || out_free;

  always_comb begin
    push_req  = 1'b0;
    push_kind = RK_NONE;
    push_word = '0;
    case (state_r)
      S_DECODE: begin
        push_req  = dec_push;
        push_kind = dec_kind;
      end
      S_DELIV: begin
        push_req  = 1'b1;
        push_kind = RK_DELIVER;
        push_word = lat_word_r;
      end
      S_SCAN_PUSH: begin
        push_req  = 1'b1;
        push_kind = RK_DELIVER;
        push_word = slot_word_rd_r;
      end
      S_FIN_END: begin
        push_req  = 1'b1;
        push_kind = RK_ENDED;
      end
      S_FIN_FIN: begin
        push_req  = 1'b1;
        push_kind = RK_FIN;
      end
      default: ;
    endcase
  end

  assign push_go  = push_req && can_push;
  assign flush_go = (state_r == S_FLUSH) && out_free;

  // ---------------------------------------------------------------------------
  // slot scan addressing and store
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] scan_idx;
  logic             scan_done;
  logic             mem_we;

  assign scan_idx  = scan_cnt_r[IDX_W-1:0];
  assign scan_done = (scan_cnt_r == CNT_W'(SLOTS));
  assign mem_we    = (state_r == S_DUP_RD) && scan_done && free_found_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_seq_mem[free_idx_r]  <= lat_seq_r;
      slot_word_mem[free_idx_r] <= lat_word_r;
    end
    slot_seq_rd_r  <= slot_seq_mem[scan_idx];
    slot_word_rd_r <= slot_word_mem[scan_idx];
  end

  // ---------------------------------------------------------------------------
  // sequencer, session state and output registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      session_r    <= LINK_LISTEN;
      agreed_r     <= WIN_W'(LOCAL_WINDOW_RST);
      head_r       <= '0;
      idle_r       <= '0;
      tally_r      <= '0;
      slot_valid_r <= '0;
      scan_cnt_r   <= '0;
      free_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            lat_op_r     <= op_t'(in_chan.operation);
            lat_kind_r   <= in_chan.packet_kind;
            lat_broken_r <= in_chan.packet_broken;
            lat_seq_r    <= in_chan.packet_seq;
            lat_peer_r   <= in_chan.peer_window;
            lat_word_r   <= in_chan.payload_word;
            state_r      <= S_DECODE;
          end
        end
        S_DECODE: begin
          session_r <= dec_link;
          if (dec_agree_ld) begin
            agreed_r <= agreed_calc;
          end
          if (dec_clear) begin
            // fresh session: empty buffer, head at zero
            slot_valid_r <= '0;
            head_r       <= '0;
            idle_r       <= '0;
            tally_r      <= '0;
          end else begin
            idle_r  <= dec_idle;
            tally_r <= dec_tally;
          end
          state_r <= dec_fsm;
        end
        S_HEADMOD: begin
          // head may sit above a modulus rewritten mid-session
          if (alu_ge) begin
            head_r <= alu_res[SEQ_W-1:0];
          end else begin
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          state_r <= alu_ge ? S_FLUSH : S_DIST;
        end
        S_DIST: begin
          tmp_r   <= alu_res;
          state_r <= alu_ge ? S_WCHK : S_WRAP;
        end
        S_WRAP: begin
          tmp_r   <= alu_res;
          state_r <= S_WCHK;
        end
        S_WCHK: begin
          if (alu_ge) begin
            state_r <= S_FLUSH;
          end else if (tmp_r == '0) begin
            state_r <= S_DELIV;
          end else begin
            scan_cnt_r   <= '0;
            free_found_r <= 1'b0;
            state_r      <= S_DUP_RD;
          end
        end
        S_DUP_RD: begin
          if (scan_done) begin
            // park the frame in the first free slot, drop it when full
            if (free_found_r) begin
              slot_valid_r[free_idx_r] <= 1'b1;
            end
            state_r <= S_FLUSH;
          end else if (!slot_valid_r[scan_idx]) begin
            if (!free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= scan_idx;
            end
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end else begin
            state_r <= S_DUP_CMP;
          end
        end
        S_DUP_CMP: begin
          if (alu_eq) begin
            // already parked: drop
            state_r <= S_FLUSH;
          end else begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
            state_r    <= S_DUP_RD;
          end
        end
        S_DELIV: begin
          if (push_go) begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          tmp_r   <= alu_res;
          state_r <= S_ADV2;
        end
        S_ADV2: begin
          head_r     <= alu_ge ? alu_res[SEQ_W-1:0] : tmp_r[SEQ_W-1:0];
          scan_cnt_r <= '0;
          state_r    <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (scan_done) begin
            state_r <= S_FLUSH;
          end else if (!slot_valid_r[scan_idx]) begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (alu_eq) begin
            state_r <= S_SCAN_PUSH;
          end else begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
            state_r    <= S_SCAN_RD;
          end
        end
        S_SCAN_PUSH: begin
          if (push_go) begin
            slot_valid_r[scan_idx] <= 1'b0;
            state_r                <= S_ADV;
          end
        end
        S_FIN_END: begin
          if (push_go) begin
            state_r <= S_FIN_FIN;
          end
        end
        S_FIN_FIN: begin
          if (push_go) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // pending result: replaced on each new result, closed out at the end
      if (push_go) begin
        pend_valid_r <= 1'b1;
        pend_kind_r  <= push_kind;
        pend_seq_r   <= ((push_kind == RK_ACK) || (push_kind == RK_NACK)) ? lat_seq_r : '0;
        pend_word_r  <= push_word;
      end else if (flush_go) begin
        pend_valid_r <= 1'b0;
      end

      // output stage; an item with no effect closes with a single none result
      if ((push_go && pend_valid_r) || flush_go) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= pend_valid_r ? pend_kind_r : RK_NONE;
        out_seq_r   <= pend_valid_r ? pend_seq_r : '0;
        out_word_r  <= pend_valid_r ? pend_word_r : '0;
        out_win_r   <= agreed_r;
        out_last_r  <= flush_go;
        out_link_r  <= session_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_kind    = out_kind_r;
  assign out_chan.reply_seq      = out_seq_r;
  assign out_chan.reply_window   = out_win_r;
  assign out_chan.delivered_word = out_word_r;
  assign out_chan.last           = out_last_r;
  assign out_chan.link_state     = out_link_r;

endmodule

`default_nettype wire
